### rtl/vssb_pkg.sv
// ----------------------------------------------------------------------------
// vssb_pkg
// Types, codes and default sizes for the versioned speculative store buffer.
// ----------------------------------------------------------------------------
package vssb_pkg;

    localparam int VSSB_ENTRIES  = 16;
    localparam int VSSB_VERSIONS = 8;

    localparam logic [2:0] OP_READ    = 3'd0;
    localparam logic [2:0] OP_WRITE   = 3'd1;
    localparam logic [2:0] OP_FREEZE  = 3'd2;
    localparam logic [2:0] OP_COMMIT  = 3'd3;
    localparam logic [2:0] OP_DISCARD = 3'd4;
    localparam logic [2:0] OP_CLEAR   = 3'd5;
    localparam logic [2:0] OP_RESET   = 3'd6;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WB    = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BUF_FULL = 2'd1;
    localparam logic [1:0] ST_HIST_FULL = 2'd2;
    localparam logic [1:0] ST_BAD_VER  = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] addr;
        logic [31:0] range_end;
        logic [31:0] value;
        logic [15:0] version;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] out_addr;
        logic [31:0] out_value;
        logic        hit;
        logic [1:0]  status;
        logic        last;
    } rsp_t;

endpackage

### rtl/vssb_node_mem.sv
// ----------------------------------------------------------------------------
// vssb_node_mem
// History node store: start version and data, one write and one read port,
// registered read data.
// ----------------------------------------------------------------------------
module vssb_node_mem #(
    parameter int NODES = 128,
    parameter int NAW   = 7
) (
    input  logic           clk,
    input  logic           rd_en,
    input  logic [NAW-1:0] rd_addr,
    output logic [15:0]    rd_start,
    output logic [31:0]    rd_data,
    input  logic           wr_en,
    input  logic [NAW-1:0] wr_addr,
    input  logic [15:0]    wr_start,
    input  logic [31:0]    wr_data
);

    logic [15:0] start_mem [NODES];
    logic [31:0] data_mem  [NODES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_mem[wr_addr] <= wr_start;
            data_mem[wr_addr]  <= wr_data;
        end
        if (rd_en)
        begin
            rd_start <= start_mem[rd_addr];
            rd_data  <= data_mem[rd_addr];
        end
    end

endmodule

### rtl/versioned_speculative_store_buffer.sv
// ----------------------------------------------------------------------------
// versioned_speculative_store_buffer
// Multi-version speculative store buffer with a sequenced entry walker.
// ----------------------------------------------------------------------------
// One request is handled at a time; req_stall is high until its final result
// has been loaded into the output register. A small sequencer walks the
// entries in order and the history nodes through the node memory, which has
// one read and one write port (a node is read in S_NRD and S_NCHK, moved in
// S_SHRD and S_SHWR). Commit may emit write-back transfers before its final
// result, and a stalled output holds the sequencer until the result register
// is free.
module versioned_speculative_store_buffer
    import vssb_pkg::*;
#(
    parameter int ENTRIES  = VSSB_ENTRIES,
    parameter int VERSIONS = VSSB_VERSIONS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data
);

    localparam int EW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int VW  = $clog2(VERSIONS);
    localparam int CW  = $clog2(VERSIONS + 1);
    localparam int NODES = ENTRIES * VERSIONS;
    localparam int NAW = $clog2(NODES);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_NRD, S_NCHK, S_SHRD, S_SHWR, S_NEXT, S_DONE, S_EMIT
    } state_t;

    state_t          state_reg, after_reg;
    req_t            req_reg;
    logic [15:0]     init_ver_reg, latest_reg, oldest_reg;
    logic            valid_reg [ENTRIES];
    logic [CW-1:0]   count_reg [ENTRIES];
    logic [31:0]     addr_mem  [ENTRIES];
    logic [EW-1:0]   e_reg, free_idx_reg;
    logic            free_found_reg, fast_reg, prev_reg;
    logic [VW-1:0]   i_reg, f_reg, j_reg;
    logic [1:0]      status_reg;
    rsp_t            pend_reg, rsp_reg;
    logic            rsp_valid_reg;
    logic            mw_en_reg;
    logic [NAW-1:0]  mw_addr_reg;
    logic [15:0]     mw_start_reg;
    logic [31:0]     mw_data_reg;

    logic            rd_en;
    logic [NAW-1:0]  rd_addr;
    logic [15:0]     rd_start;
    logic [31:0]     rd_data;
    logic [31:0]     e_addr;
    logic [CW-1:0]   e_count;
    logic            e_valid, e_last, e_match;
    logic [16:0]     vp1, start17;
    logic [EW-1:0]   alloc_idx;
    logic            rsp_free;

    function automatic logic [NAW-1:0] nidx(logic [EW-1:0] e, logic [VW-1:0] i);
        return NAW'(NAW'(e) * NAW'(VERSIONS)) + NAW'(i);
    endfunction

    vssb_node_mem #(.NODES(NODES), .NAW(NAW)) u_mem (
        .clk      (clk),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_start (rd_start),
        .rd_data  (rd_data),
        .wr_en    (mw_en_reg),
        .wr_addr  (mw_addr_reg),
        .wr_start (mw_start_reg),
        .wr_data  (mw_data_reg)
    );

    assign e_addr    = addr_mem[e_reg];
    assign e_count   = count_reg[e_reg];
    assign e_valid   = valid_reg[e_reg];
    assign e_last    = (e_reg == EW'(ENTRIES - 1));
    assign e_match   = e_valid && (e_addr == req_reg.addr);
    assign vp1       = {1'b0, req_reg.version} + 17'd1;
    assign start17   = {1'b0, rd_start};
    assign alloc_idx = free_found_reg ? free_idx_reg : e_reg;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = nidx(e_reg, i_reg);
        case (state_reg)
            S_NRD:
            begin
                rd_en = 1'b1;
            end
            S_SHRD:
            begin
                rd_en   = 1'b1;
                rd_addr = nidx(e_reg, VW'(j_reg + f_reg));
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SCAN && (req_reg.op == OP_READ || req_reg.op == OP_WRITE))
        begin
            if (req_reg.op == OP_WRITE && !e_match && e_last &&
                (free_found_reg || !e_valid))
            begin
                addr_mem[alloc_idx] <= req_reg.addr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            after_reg      <= S_IDLE;
            init_ver_reg   <= '0;
            latest_reg     <= '0;
            oldest_reg     <= '0;
            for (int k = 0; k < ENTRIES; k++)
            begin
                valid_reg[k] <= 1'b0;
                count_reg[k] <= '0;
            end
            e_reg          <= '0;
            free_idx_reg   <= '0;
            free_found_reg <= 1'b0;
            fast_reg       <= 1'b0;
            prev_reg       <= 1'b0;
            i_reg          <= '0;
            f_reg          <= '0;
            j_reg          <= '0;
            status_reg     <= ST_OK;
            rsp_valid_reg  <= 1'b0;
            mw_en_reg      <= 1'b0;
        end
        else
        begin
            mw_en_reg <= 1'b0;
            if (cfg_we)
            begin
                init_ver_reg <= cfg_data;
            end
            if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_reg        <= req;
                        e_reg          <= '0;
                        free_found_reg <= 1'b0;
                        prev_reg       <= 1'b0;
                        status_reg     <= ST_OK;
                        fast_reg       <= (req.version == latest_reg);
                        state_reg      <= S_DONE;
                        case (req.op)
                            OP_READ, OP_WRITE, OP_CLEAR:
                            begin
                                state_reg <= S_SCAN;
                            end
                            OP_FREEZE:
                            begin
                                if (latest_reg == 16'hFFFF)
                                    status_reg <= ST_BAD_VER;
                                else
                                    latest_reg <= latest_reg + 16'd1;
                            end
                            OP_COMMIT:
                            begin
                                if (req.version > latest_reg)
                                    status_reg <= ST_BAD_VER;
                                else
                                begin
                                    oldest_reg <= req.version;
                                    state_reg  <= S_SCAN;
                                end
                            end
                            OP_DISCARD:
                            begin
                                if (req.version < oldest_reg)
                                    status_reg <= ST_BAD_VER;
                                else
                                    state_reg <= S_SCAN;
                            end
                            OP_RESET:
                            begin
                                for (int k = 0; k < ENTRIES; k++)
                                begin
                                    valid_reg[k] <= 1'b0;
                                    count_reg[k] <= '0;
                                end
                                latest_reg <= init_ver_reg;
                                oldest_reg <= init_ver_reg;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end

                S_SCAN:
                begin
                    i_reg <= VW'(e_count - CW'(1));
                    case (req_reg.op)
                        OP_READ, OP_WRITE:
                        begin
                            if (e_match)
                                state_reg <= S_NRD;
                            else
                            begin
                                if (!e_valid && !free_found_reg)
                                begin
                                    free_found_reg <= 1'b1;
                                    free_idx_reg   <= e_reg;
                                end
                                if (!e_last)
                                    e_reg <= e_reg + EW'(1);
                                else if (req_reg.op == OP_READ)
                                begin
                                    pend_reg  <= '{KIND_READ, req_reg.addr, 32'd0,
                                                   1'b0, ST_OK, 1'b1};
                                    after_reg <= S_IDLE;
                                    state_reg <= S_EMIT;
                                end
                                else
                                begin
                                    state_reg <= S_DONE;
                                    if (free_found_reg || !e_valid)
                                    begin
                                        valid_reg[alloc_idx] <= 1'b1;
                                        count_reg[alloc_idx] <= CW'(1);
                                        mw_en_reg    <= 1'b1;
                                        mw_addr_reg  <= nidx(alloc_idx, '0);
                                        mw_start_reg <= latest_reg;
                                        mw_data_reg  <= req_reg.value;
                                    end
                                    else
                                        status_reg <= ST_BUF_FULL;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            if (e_valid && e_addr >= req_reg.addr &&
                                e_addr < req_reg.range_end)
                            begin
                                valid_reg[e_reg] <= 1'b0;
                                count_reg[e_reg] <= '0;
                            end
                            state_reg <= S_NEXT;
                        end
                        default:
                        begin
                            prev_reg  <= 1'b0;
                            state_reg <= e_valid ? S_NRD : S_NEXT;
                        end
                    endcase
                end

                S_NRD:
                begin
                    state_reg <= S_NCHK;
                end

                S_NCHK:
                begin
                    case (req_reg.op)
                        OP_READ:
                        begin
                            pend_reg  <= '{KIND_READ, req_reg.addr, rd_data,
                                           1'b1, ST_OK, 1'b1};
                            after_reg <= S_IDLE;
                            state_reg <= S_EMIT;
                        end
                        OP_WRITE:
                        begin
                            state_reg <= S_DONE;
                            if (rd_start == latest_reg)
                            begin
                                mw_en_reg    <= 1'b1;
                                mw_addr_reg  <= nidx(e_reg, i_reg);
                                mw_start_reg <= rd_start;
                                mw_data_reg  <= req_reg.value;
                            end
                            else if (rd_start > latest_reg)
                                status_reg <= ST_BAD_VER;
                            else if (e_count >= CW'(VERSIONS))
                                status_reg <= ST_HIST_FULL;
                            else
                            begin
                                mw_en_reg    <= 1'b1;
                                mw_addr_reg  <= nidx(e_reg, VW'(i_reg + VW'(1)));
                                mw_start_reg <= latest_reg;
                                mw_data_reg  <= req_reg.value;
                                count_reg[e_reg] <= e_count + CW'(1);
                            end
                        end
                        OP_COMMIT:
                        begin
                            j_reg <= '0;
                            if (fast_reg)
                            begin
                                pend_reg  <= '{KIND_WB, e_addr, rd_data, 1'b0, ST_OK, 1'b0};
                                valid_reg[e_reg] <= 1'b0;
                                count_reg[e_reg] <= '0;
                                after_reg <= S_NEXT;
                                state_reg <= S_EMIT;
                            end
                            else if (prev_reg)
                            begin
                                pend_reg  <= '{KIND_WB, e_addr, rd_data, 1'b0, ST_OK, 1'b0};
                                after_reg <= S_SHRD;
                                state_reg <= S_EMIT;
                            end
                            else if (start17 <= vp1)
                            begin
                                f_reg <= i_reg;
                                if (start17 == vp1)
                                begin
                                    if (i_reg != '0)
                                    begin
                                        prev_reg  <= 1'b1;
                                        i_reg     <= i_reg - VW'(1);
                                        state_reg <= S_NRD;
                                    end
                                    else
                                        state_reg <= S_NEXT;
                                end
                                else
                                begin
                                    pend_reg     <= '{KIND_WB, e_addr, rd_data,
                                                      1'b0, ST_OK, 1'b0};
                                    mw_en_reg    <= 1'b1;
                                    mw_addr_reg  <= nidx(e_reg, i_reg);
                                    mw_start_reg <= vp1[15:0];
                                    mw_data_reg  <= rd_data;
                                    after_reg    <= (i_reg != '0) ? S_SHRD : S_NEXT;
                                    state_reg    <= S_EMIT;
                                end
                            end
                            else if (i_reg == '0)
                                state_reg <= S_NEXT;
                            else
                            begin
                                i_reg     <= i_reg - VW'(1);
                                state_reg <= S_NRD;
                            end
                        end
                        OP_DISCARD:
                        begin
                            if (start17 + 17'd1 <= {1'b0, req_reg.version})
                            begin
                                count_reg[e_reg] <= CW'(i_reg) + CW'(1);
                                state_reg <= S_NEXT;
                            end
                            else if (i_reg == '0)
                            begin
                                valid_reg[e_reg] <= 1'b0;
                                count_reg[e_reg] <= '0;
                                state_reg <= S_NEXT;
                            end
                            else
                            begin
                                i_reg     <= i_reg - VW'(1);
                                state_reg <= S_NRD;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end

                S_SHRD:
                begin
                    state_reg <= S_SHWR;
                end

                S_SHWR:
                begin
                    mw_en_reg    <= 1'b1;
                    mw_addr_reg  <= nidx(e_reg, j_reg);
                    mw_start_reg <= rd_start;
                    mw_data_reg  <= rd_data;
                    if (CW'(j_reg) + CW'(f_reg) + CW'(1) >= e_count)
                    begin
                        count_reg[e_reg] <= e_count - CW'(f_reg);
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        j_reg     <= j_reg + VW'(1);
                        state_reg <= S_SHRD;
                    end
                end

                S_NEXT:
                begin
                    if (e_last)
                    begin
                        state_reg <= S_DONE;
                        if (req_reg.op == OP_DISCARD)
                        begin
                            if (req_reg.version == 16'd0 ||
                                req_reg.version - 16'd1 < oldest_reg)
                                latest_reg <= oldest_reg;
                            else
                                latest_reg <= req_reg.version - 16'd1;
                        end
                    end
                    else
                    begin
                        e_reg     <= e_reg + EW'(1);
                        state_reg <= S_SCAN;
                    end
                end

                S_DONE:
                begin
                    pend_reg  <= '{KIND_DONE, 32'd0, 32'd0, 1'b0, status_reg, 1'b1};
                    after_reg <= S_IDLE;
                    state_reg <= S_EMIT;
                end

                S_EMIT:
                begin
                    if (rsp_free)
                    begin
                        rsp_reg       <= pend_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= after_reg;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### dv/tb_versioned_speculative_store_buffer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_versioned_speculative_store_buffer
// Self-checking bench: a directed sequence over every operation and corner
// (misses, full buffer and history, bad versions, freeze at maximum, empty and
// reversed clear ranges) then random traffic over a small address pool under
// several initial versions. A behavioural copy of the buffer predicts every
// result; results are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_versioned_speculative_store_buffer;
    import vssb_pkg::*;

    localparam int NENT = VSSB_ENTRIES;
    localparam int NVER = VSSB_VERSIONS;
    localparam int IDLE_LIMIT = 40000;
    localparam logic [2:0] OP_UNDEF = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;
    logic        cfg_we;
    logic [15:0] cfg_data;

    versioned_speculative_store_buffer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // shadow buffer
    logic        sh_valid [NENT];
    logic [31:0] sh_addr  [NENT];
    int          sh_count [NENT];
    int          sh_start [NENT][NVER];
    logic [31:0] sh_data  [NENT][NVER];
    int          sh_latest;
    int          sh_oldest;
    int          sh_init_ver;

    req_t pending_req_q[$];
    rsp_t rsp_expected_q[$];
    int   errors;
    bit   quiet;
    int   gen_ver;
    logic [31:0] addr_pool [20];

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic rsp_t mk_rsp(logic [1:0] k, logic [31:0] a, logic [31:0] v,
                                    logic h, logic [1:0] st, logic l);
        rsp_t r;
        r.kind = k;
        r.out_addr = a;
        r.out_value = v;
        r.hit = h;
        r.status = st;
        r.last = l;
        return r;
    endfunction

    function automatic void expect_rsp(rsp_t r);
        rsp_expected_q = {rsp_expected_q, r};
    endfunction

    function automatic int find_slot(logic [31:0] a);
        for (int e = 0; e < NENT; e++)
            if (sh_valid[e] && sh_addr[e] == a)
                return e;
        return -1;
    endfunction

    function automatic logic [1:0] shadow_write(logic [31:0] a, logic [31:0] v);
        int e;
        int n;
        e = find_slot(a);
        if (e < 0) begin
            for (e = 0; e < NENT; e++)
                if (!sh_valid[e])
                    break;
            if (e >= NENT)
                return ST_BUF_FULL;
            sh_valid[e] = 1'b1;
            sh_addr[e] = a;
            sh_count[e] = 1;
            sh_start[e][0] = sh_latest;
            sh_data[e][0] = v;
            return ST_OK;
        end
        n = sh_count[e];
        if (sh_start[e][n-1] == sh_latest) begin
            sh_data[e][n-1] = v;
            return ST_OK;
        end
        if (sh_start[e][n-1] > sh_latest)
            return ST_BAD_VER;
        if (n >= NVER)
            return ST_HIST_FULL;
        sh_start[e][n] = sh_latest;
        sh_data[e][n] = v;
        sh_count[e] = n + 1;
        return ST_OK;
    endfunction

    function automatic logic [1:0] shadow_commit(int ver);
        int n;
        int f;
        if (ver > sh_latest)
            return ST_BAD_VER;
        sh_oldest = ver;
        for (int e = 0; e < NENT; e++) begin
            if (!sh_valid[e])
                continue;
            n = sh_count[e];
            if (ver == sh_latest) begin
                expect_rsp(mk_rsp(KIND_WB, sh_addr[e], sh_data[e][n-1],
                                  1'b0, ST_OK, 1'b0));
                sh_valid[e] = 1'b0;
                sh_count[e] = 0;
                continue;
            end
            f = -1;
            for (int i = n - 1; i >= 0; i--)
                if (sh_start[e][i] <= ver + 1) begin
                    f = i;
                    break;
                end
            if (f < 0)
                continue;
            if (sh_start[e][f] == ver + 1) begin
                if (f > 0)
                    expect_rsp(mk_rsp(KIND_WB, sh_addr[e], sh_data[e][f-1],
                                      1'b0, ST_OK, 1'b0));
            end
            else begin
                expect_rsp(mk_rsp(KIND_WB, sh_addr[e], sh_data[e][f],
                                  1'b0, ST_OK, 1'b0));
                sh_start[e][f] = ver + 1;
            end
            for (int j = 0; j + f < n; j++) begin
                sh_start[e][j] = sh_start[e][j+f];
                sh_data[e][j] = sh_data[e][j+f];
            end
            sh_count[e] = n - f;
        end
        return ST_OK;
    endfunction

    function automatic logic [1:0] shadow_discard(int ver);
        int keep;
        if (ver < sh_oldest)
            return ST_BAD_VER;
        for (int e = 0; e < NENT; e++) begin
            if (!sh_valid[e])
                continue;
            keep = 0;
            for (int i = sh_count[e] - 1; i >= 0; i--)
                if (sh_start[e][i] + 1 <= ver) begin
                    keep = i + 1;
                    break;
                end
            sh_count[e] = keep;
            if (keep == 0)
                sh_valid[e] = 1'b0;
        end
        sh_latest = (ver == 0) ? 0 : ver - 1;
        if (sh_latest < sh_oldest)
            sh_latest = sh_oldest;
        return ST_OK;
    endfunction

    function automatic void shadow_empty();
        for (int e = 0; e < NENT; e++) begin
            sh_valid[e] = 1'b0;
            sh_count[e] = 0;
        end
        sh_latest = sh_init_ver;
        sh_oldest = sh_init_ver;
    endfunction

    function automatic void predict_results(req_t r);
        int e;
        logic [1:0] st;
        st = ST_OK;
        case (r.op)
            OP_READ:
            begin
                e = find_slot(r.addr);
                if (e < 0)
                    expect_rsp(mk_rsp(KIND_READ, r.addr, '0, 1'b0, ST_OK, 1'b1));
                else
                    expect_rsp(mk_rsp(KIND_READ, r.addr, sh_data[e][sh_count[e]-1],
                                      1'b1, ST_OK, 1'b1));
                return;
            end
            OP_WRITE:   st = shadow_write(r.addr, r.value);
            OP_FREEZE:
            begin
                if (sh_latest >= 16'hFFFF)
                    st = ST_BAD_VER;
                else
                    sh_latest++;
            end
            OP_COMMIT:  st = shadow_commit(int'(r.version));
            OP_DISCARD: st = shadow_discard(int'(r.version));
            OP_CLEAR:
            begin
                for (e = 0; e < NENT; e++)
                    if (sh_valid[e] && sh_addr[e] >= r.addr && sh_addr[e] < r.range_end)
                    begin
                        sh_valid[e] = 1'b0;
                        sh_count[e] = 0;
                    end
            end
            OP_RESET:   shadow_empty();
            default:    ;
        endcase
        expect_rsp(mk_rsp(KIND_DONE, '0, '0, 1'b0, st, 1'b1));
    endfunction

    // ---- stimulus helpers
    function automatic req_t mk_req(logic [2:0] op, logic [31:0] a, logic [31:0] re,
                                    logic [31:0] v, logic [15:0] ver);
        req_t r;
        r.op = op;
        r.addr = a;
        r.range_end = re;
        r.value = v;
        r.version = ver;
        return r;
    endfunction

    task automatic queue_op(logic [2:0] op, logic [31:0] a, logic [31:0] re,
                            logic [31:0] v, logic [15:0] ver);
        pending_req_q = {pending_req_q, mk_req(op, a, re, v, ver)};
    endtask

    function automatic logic [31:0] pick_addr();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return addr_pool[$urandom_range(0, 19)];
    endfunction

    task automatic queue_random(int count, int init_ver);
        int sel;
        logic [2:0] op;
        logic [15:0] ver;
        logic [31:0] a;
        logic [31:0] re;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 25)      op = OP_READ;
            else if (sel < 60) op = OP_WRITE;
            else if (sel < 74) op = OP_FREEZE;
            else if (sel < 83) op = OP_COMMIT;
            else if (sel < 91) op = OP_DISCARD;
            else if (sel < 96) op = OP_CLEAR;
            else if (sel < 98) op = OP_RESET;
            else               op = OP_UNDEF;
            sel = $urandom_range(0, 9);
            if (sel < 7)      ver = 16'(gen_ver - $urandom_range(0, 3));
            else if (sel < 9) ver = 16'(gen_ver + $urandom_range(0, 2));
            else              ver = 16'($urandom);
            a = pick_addr();
            re = pick_addr();
            if (op == OP_CLEAR && $urandom_range(0, 3) == 0) begin
                a = '0;
                re = '1;
            end
            case (op)
                OP_FREEZE:  if (gen_ver < 16'hFFFF) gen_ver++;
                OP_DISCARD: gen_ver = (ver == 0) ? 0 : ver - 1;
                OP_RESET:   gen_ver = init_ver;
                default:    ;
            endcase
            queue_op(op, a, re, $urandom, ver);
        end
    endtask

    task automatic drain();
        wait (pending_req_q.size() == 0 && !req_valid && rsp_expected_q.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_init_ver(logic [15:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        sh_init_ver = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // ---- driver
    int req_gap;
    always @(posedge clk or negedge rst_n) begin
        logic nxt_valid;
        req_t nxt_req;
        if (!rst_n) begin
            req_valid <= 1'b0;
            req <= '0;
            req_gap <= 0;
        end
        else begin
            nxt_valid = req_valid;
            nxt_req = req;
            if (req_valid && !req_stall) begin
                predict_results(req);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (req_gap > 0)
                    req_gap <= req_gap - 1;
                else if (pending_req_q.size() > 0) begin
                    if (!quiet && $urandom_range(0, 5) == 0)
                        req_gap <= $urandom_range(0, 3);
                    else begin
                        nxt_valid = 1'b1;
                        nxt_req = pending_req_q.pop_front();
                    end
                end
            end
            req_valid <= nxt_valid;
            req <= nxt_req;
        end
    end

    // ---- receiver, checker and watchdog
    int rsp_gap;
    int idle_cycles;
    always @(posedge clk or negedge rst_n) begin
        rsp_t want;
        if (!rst_n) begin
            rsp_stall <= 1'b0;
            rsp_gap <= 0;
            idle_cycles <= 0;
        end
        else begin
            if (rsp_valid && !rsp_stall) begin
                if (rsp_expected_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result: expected none, actual %p", $time, rsp);
                end
                else begin
                    want = rsp_expected_q.pop_front();
                    if (rsp.kind != want.kind) begin
                        errors++;
                        $display("%0t kind: expected %0d, actual %0d", $time,
                                 want.kind, rsp.kind);
                    end
                    if (rsp.out_addr != want.out_addr) begin
                        errors++;
                        $display("%0t out_addr: expected %h, actual %h", $time,
                                 want.out_addr, rsp.out_addr);
                    end
                    if (rsp.out_value != want.out_value) begin
                        errors++;
                        $display("%0t out_value: expected %h, actual %h", $time,
                                 want.out_value, rsp.out_value);
                    end
                    if (rsp.hit != want.hit) begin
                        errors++;
                        $display("%0t hit: expected %0d, actual %0d", $time, want.hit, rsp.hit);
                    end
                    if (rsp.status != want.status) begin
                        errors++;
                        $display("%0t status: expected %0d, actual %0d", $time,
                                 want.status, rsp.status);
                    end
                    if (rsp.last != want.last) begin
                        errors++;
                        $display("%0t last: expected %0d, actual %0d", $time,
                                 want.last, rsp.last);
                    end
                end
            end
            if (quiet)
                rsp_stall <= 1'b0;
            else if (rsp_gap > 0) begin
                rsp_gap <= rsp_gap - 1;
                rsp_stall <= 1'b1;
            end
            else if ($urandom_range(0, 4) == 0) begin
                rsp_gap <= $urandom_range(0, 3);
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;

            if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) ||
                (rsp_expected_q.size() == 0 && !req_valid))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT) begin
                $display("[versioned_speculative_store_buffer] ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ---- sequence
    initial begin
        logic [31:0] a_lo;
        logic [31:0] a_hi;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        quiet = 1'b0;
        errors = 0;
        sh_init_ver = 0;
        shadow_empty();
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int i = 2; i < 20; i++)
            addr_pool[i] = $urandom;
        a_lo = '0;
        a_hi = '1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        write_init_ver(16'd0);
        queue_op(OP_READ, a_lo, '0, '0, '0);
        queue_op(OP_WRITE, a_lo, '1, '1, '1);
        queue_op(OP_READ, a_lo, '0, '0, '0);
        queue_op(OP_WRITE, a_hi, '0, '0, '0);
        queue_op(OP_FREEZE, '0, '0, '0, '0);
        queue_op(OP_WRITE, a_lo, '0, 32'h1, '0);
        queue_op(OP_COMMIT, '0, '0, '0, 16'd5);
        queue_op(OP_COMMIT, '0, '0, '0, 16'd0);
        queue_op(OP_DISCARD, '0, '0, '0, 16'hFFFF);
        queue_op(OP_COMMIT, '0, '0, '0, 16'd1);
        queue_op(OP_DISCARD, '0, '0, '0, 16'd0);
        queue_op(OP_WRITE, a_lo, '0, 32'h7, '0);
        queue_op(OP_DISCARD, '0, '0, '0, 16'd0);
        queue_op(OP_CLEAR, 32'd10, 32'd5, '0, '0);
        queue_op(OP_CLEAR, 32'd5, 32'd5, '0, '0);
        queue_op(OP_UNDEF, '1, '1, '1, '1);
        for (int i = 0; i <= NENT; i++)
            queue_op(OP_WRITE, 32'(i * 3), '0, $urandom, '0);
        queue_op(OP_CLEAR, a_lo, a_hi, '0, '0);
        queue_op(OP_WRITE, a_lo, '0, $urandom, '0);
        for (int i = 0; i < NVER; i++) begin
            queue_op(OP_FREEZE, '0, '0, '0, '0);
            queue_op(OP_WRITE, a_lo, '0, $urandom, '0);
        end
        queue_op(OP_DISCARD, '0, '0, '0, 16'd1);
        drain();

        write_init_ver(16'hFFFF);
        queue_op(OP_RESET, '0, '0, '0, '0);
        queue_op(OP_WRITE, a_hi, '0, $urandom, '0);
        queue_op(OP_FREEZE, '0, '0, '0, '0);
        gen_ver = 16'hFFFF;
        queue_random(180, 16'hFFFF);
        drain();

        write_init_ver(16'($urandom));
        queue_op(OP_RESET, '0, '0, '0, '0);
        gen_ver = sh_init_ver;
        queue_random(190, sh_init_ver);
        drain();

        write_init_ver(16'd3);
        quiet = 1'b1;
        queue_op(OP_RESET, '0, '0, '0, '0);
        gen_ver = 3;
        queue_random(70, 3);
        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("[versioned_speculative_store_buffer] OK");
        else
            $display("[versioned_speculative_store_buffer] ERROR");
        $finish;
    end

endmodule
